// ===== sv/segregated_fit_buffer_allocator_assert.svh =====
// ----------------------------------------------------------------------------
// Assertion macros for the segregated fit buffer allocator
// Concurrent checks that compile to nothing when SYNTHESIS is defined.
// ----------------------------------------------------------------------------
`ifndef SEGREGATED_FIT_BUFFER_ALLOCATOR_ASSERT_SVH
`define SEGREGATED_FIT_BUFFER_ALLOCATOR_ASSERT_SVH

`ifndef SYNTHESIS

// The condition must never hold while out of reset.
`define SFBA_ASSERT_NEVER(lbl, cond, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) !(cond)) else $error(msg);

// Whenever the trigger holds, the consequence must hold in the following cycle.
`define SFBA_ASSERT_NEXT(lbl, trig, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (trig) |=> (cons)) else $error(msg);

// Whenever the trigger holds, the consequence must hold in the same cycle.
`define SFBA_ASSERT_SAME(lbl, trig, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (trig) |-> (cons)) else $error(msg);

`else

`define SFBA_ASSERT_NEVER(lbl, cond, msg)
`define SFBA_ASSERT_NEXT(lbl, trig, cons, msg)
`define SFBA_ASSERT_SAME(lbl, trig, cons, msg)

`endif

`endif

// ===== sv/sfba_pkg.sv =====
// ----------------------------------------------------------------------------
// Segregated fit buffer allocator package
// Sizes, node record layout, status codes and bucket helper functions.
// ----------------------------------------------------------------------------
package sfba_pkg;

  // Slot table and pointer widths; the null pointer is NODE_SLOTS.
  localparam int NODE_SLOTS = 256;
  localparam int SLOT_W     = $clog2(NODE_SLOTS);
  localparam int PTR_W      = SLOT_W + 1;

  // Size buckets.
  localparam int BUCKETS      = 12;
  localparam int FIRST_BUCKET = 4;
  localparam int BKT_W        = $clog2(BUCKETS + 1);

  // Pools.
  localparam int MAX_POOLS  = 16;
  localparam int POOL_CNT_W = $clog2(MAX_POOLS + 1);
  localparam int POOL_W     = 4;

  // Item counts and sizes.
  localparam int CNT_W             = 17;
  localparam int SIZE_W            = 16;
  localparam int VERTEX_POOL_ITEMS = 65535;
  localparam int INDEX_POOL_ITEMS  = 65535;
  localparam int INDEX_LIMIT       = INDEX_POOL_ITEMS / 3;
  localparam int SLACK_RESET       = 100;

  // Free slot search works on groups of slots.
  localparam int GRP_SIZE = 16;
  localparam int GRP_W    = $clog2(GRP_SIZE);
  localparam int GROUPS   = NODE_SLOTS / GRP_SIZE;
  localparam int GSEL_W   = $clog2(GROUPS);

  typedef logic [PTR_W-1:0]  ptr_t;
  typedef logic [SLOT_W-1:0] slot_t;

  localparam ptr_t NIL = PTR_W'(NODE_SLOTS);

  typedef enum logic [1:0] {
    STATUS_OK        = 2'd0,
    STATUS_TOO_LARGE = 2'd1,
    STATUS_NO_POOL   = 2'd2,
    STATUS_NO_SLOT   = 2'd3
  } status_t;

  // One node record as held in the node memory.
  typedef struct packed {
    logic [SIZE_W-1:0] size;
    logic [SIZE_W-1:0] off;
    logic [POOL_W-1:0] pool;
    logic              busy;
    ptr_t              anext;
    ptr_t              aprev;
    ptr_t              bnext;
    ptr_t              bprev;
  } node_t;

  // Per-field write enables of the node memory.
  typedef struct packed {
    logic size;
    logic off;
    logic pool;
    logic busy;
    logic anext;
    logic aprev;
    logic bnext;
    logic bprev;
  } node_mask_t;

  // A pointer refers to a slot when it is below the null value.
  function automatic logic live(input ptr_t p);
    return !p[PTR_W-1];
  endfunction

  // Bucket index from ceil(log2 count), offset and clamped.
  function automatic logic [BKT_W-1:0] bucket_of(input logic [CNT_W-1:0] cnt);
    logic [CNT_W-1:0] m;
    int unsigned      lg;
    m  = cnt - CNT_W'(1);
    lg = 0;
    if (cnt > CNT_W'(1)) begin
      for (int i = 0; i < CNT_W; i++) begin
        if (m[i]) lg = i + 1;
      end
    end
    if (lg < FIRST_BUCKET) begin
      return '0;
    end else if (lg - FIRST_BUCKET > BUCKETS - 1) begin
      return BKT_W'(BUCKETS - 1);
    end else begin
      return BKT_W'(lg - FIRST_BUCKET);
    end
  endfunction

endpackage

// ===== sv/segregated_fit_buffer_allocator.sv =====
// ----------------------------------------------------------------------------
// Segregated fit buffer allocator
// Vertex and index region allocator with size buckets and coalescing.
// ----------------------------------------------------------------------------
// Usage:
//   A command transfer happens when start is high and busy is low. req_type
//   selects allocate or free, is_vertex the allocator, item_count the size
//   and node_handle the region to free. Each command gives one result
//   (status and, on a granted allocate, the region; zero otherwise), shown
//   for one cycle with done high; the receiver cannot stall. busy falls in
//   the cycle that done is high, so a new command may start there.
//   split_slack is written through cfg_we and cfg_wdata; the user must
//   write it only while idle, as the block itself does not enforce this.
//   An allocate takes longer for each bucket passed over, each node
//   rejected and for a split. Each chain walk is capped at 256 nodes,
//   so a scan ends even when a mislabelled free has looped a chain.
// Reset:
//   All slots free, all bucket heads null, no pools open, split_slack 100.
// ----------------------------------------------------------------------------
`include "segregated_fit_buffer_allocator_assert.svh"

module segregated_fit_buffer_allocator (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             start,
  output logic                             busy,
  input  logic                             req_type,
  input  logic                             is_vertex,
  input  logic [sfba_pkg::CNT_W-1:0]       item_count,
  input  logic [sfba_pkg::SLOT_W-1:0]      node_handle,
  input  logic                             cfg_we,
  input  logic [sfba_pkg::SIZE_W-1:0]      cfg_wdata,
  output logic                             done,
  output logic [1:0]                       status,
  output logic [sfba_pkg::SLOT_W-1:0]      region_handle,
  output logic [sfba_pkg::SIZE_W-1:0]      region_offset,
  output logic [sfba_pkg::POOL_W-1:0]      region_pool,
  output logic [sfba_pkg::SIZE_W-1:0]      region_size
);

  typedef enum logic [4:0] {
    S_IDLE, S_A_START, S_A_HEAD, S_A_WALK, S_A_CHK, S_A_NOFIT, S_A_POOL,
    S_A_SPCHK, S_A_SP1, S_A_SP2, S_A_SP3, S_A_SP4, S_A_SP5, S_A_GRANT,
    S_UL1, S_UL2, S_UL3, S_SF_G, S_SF_B,
    S_F_START, S_F_CHKH, S_F_CHKR, S_F_MR1, S_F_MR2, S_F_RDH2, S_F_LFT,
    S_F_CHKL, S_F_ML1, S_F_ML2, S_F_LINK, S_F_LINK2
  } state_t;

  // Command and control registers.
  state_t                            st;
  state_t                            ret;
  state_t                            sret;
  logic                              is_v;
  logic [sfba_pkg::CNT_W-1:0]        n;
  sfba_pkg::slot_t                   hnd;
  logic [sfba_pkg::SIZE_W-1:0]       slack;
  logic [sfba_pkg::POOL_CNT_W-1:0]   pools;
  logic [sfba_pkg::NODE_SLOTS-1:0]   sfree;
  sfba_pkg::ptr_t                    vhead [sfba_pkg::BUCKETS];
  sfba_pkg::ptr_t                    ihead [sfba_pkg::BUCKETS];

  // Walk and working registers.
  logic [sfba_pkg::BKT_W-1:0]        e;
  sfba_pkg::ptr_t                    cur;
  logic [sfba_pkg::PTR_W-1:0]        steps;
  sfba_pkg::slot_t                   found;
  logic [sfba_pkg::SIZE_W-1:0]       fsize;
  logic [sfba_pkg::SIZE_W-1:0]       foff;
  logic [sfba_pkg::POOL_W-1:0]       fpool;
  sfba_pkg::ptr_t                    fanext;
  sfba_pkg::ptr_t                    hd_old;
  sfba_pkg::slot_t                   ux;
  sfba_pkg::ptr_t                    un;
  sfba_pkg::ptr_t                    up;
  logic [sfba_pkg::SIZE_W-1:0]       usz;
  logic [sfba_pkg::SIZE_W-1:0]       tsz;
  sfba_pkg::ptr_t                    tnext;
  sfba_pkg::slot_t                   fh;
  logic                              slot_ok;
  sfba_pkg::slot_t                   slot;
  logic [sfba_pkg::GSEL_W-1:0]       grp;

  // Node memory ports.
  sfba_pkg::node_t                   mem [sfba_pkg::NODE_SLOTS];
  sfba_pkg::node_t                   rdata;
  sfba_pkg::node_t                   wd;
  sfba_pkg::node_mask_t              wm;
  sfba_pkg::slot_t                   wa;
  sfba_pkg::slot_t                   ra;

  // Bucket head port.
  logic [sfba_pkg::BKT_W-1:0]        hd_idx;
  logic                              hd_we;
  sfba_pkg::ptr_t                    hd_wd;
  sfba_pkg::ptr_t                    hd_rd;

  // Free slot search.
  logic [sfba_pkg::GROUPS-1:0]       grp_any;
  logic [sfba_pkg::GSEL_W-1:0]       grp_pick;
  logic [sfba_pkg::GRP_SIZE-1:0]     grp_word;
  logic [sfba_pkg::GRP_W-1:0]        pos_pick;

  logic [sfba_pkg::SIZE_W-1:0]       n16;
  logic [sfba_pkg::SIZE_W-1:0]       sp_size;
  logic [sfba_pkg::SIZE_W-1:0]       pool_items;

  assign busy       = (st != S_IDLE);
  assign n16        = n[sfba_pkg::SIZE_W-1:0];
  assign sp_size    = fsize - n16;
  assign pool_items = is_v ? sfba_pkg::SIZE_W'(sfba_pkg::VERTEX_POOL_ITEMS)
                           : sfba_pkg::SIZE_W'(sfba_pkg::INDEX_POOL_ITEMS);
  assign hd_rd      = is_v ? vhead[hd_idx] : ihead[hd_idx];

  // Lowest free slot: first the lowest group with a free slot, then the
  // lowest free slot within the chosen group.
  always_comb begin
    grp_pick = '0;
    pos_pick = '0;
    for (int g = 0; g < sfba_pkg::GROUPS; g++) begin
      grp_any[g] = |sfree[g*sfba_pkg::GRP_SIZE +: sfba_pkg::GRP_SIZE];
    end
    for (int g = sfba_pkg::GROUPS - 1; g >= 0; g--) begin
      if (grp_any[g]) grp_pick = sfba_pkg::GSEL_W'(g);
    end
    grp_word = sfree[{grp, sfba_pkg::GRP_W'(0)} +: sfba_pkg::GRP_SIZE];
    for (int b = sfba_pkg::GRP_SIZE - 1; b >= 0; b--) begin
      if (grp_word[b]) pos_pick = sfba_pkg::GRP_W'(b);
    end
  end

  // Memory and bucket head accesses for each step of the sequencer.
  always_comb begin
    wm     = '0;
    wa     = '0;
    wd     = '0;
    ra     = '0;
    hd_idx = '0;
    hd_we  = 1'b0;
    hd_wd  = sfba_pkg::NIL;
    case (st)
      S_A_HEAD: begin
        if (e < sfba_pkg::BKT_W'(sfba_pkg::BUCKETS)) hd_idx = e;
      end
      S_A_WALK: begin
        ra = cur[sfba_pkg::SLOT_W-1:0];
      end
      S_A_POOL: begin
        if (slot_ok) begin
          wm       = '1;
          wa       = slot;
          wd.size  = pool_items;
          wd.off   = '0;
          wd.pool  = pools[sfba_pkg::POOL_W-1:0];
          wd.busy  = 1'b1;
          wd.anext = sfba_pkg::NIL;
          wd.aprev = sfba_pkg::NIL;
          wd.bnext = sfba_pkg::NIL;
          wd.bprev = sfba_pkg::NIL;
        end
      end
      S_A_SP1: begin
        if (slot_ok) begin
          hd_idx   = sfba_pkg::bucket_of({1'b0, sp_size});
          wm       = '1;
          wa       = slot;
          wd.size  = sp_size;
          wd.off   = foff + n16;
          wd.pool  = fpool;
          wd.busy  = 1'b0;
          wd.anext = fanext;
          wd.aprev = {1'b0, found};
          wd.bnext = hd_rd;
          wd.bprev = sfba_pkg::NIL;
          hd_we    = 1'b1;
          hd_wd    = {1'b0, slot};
        end
      end
      S_A_SP2: begin
        wm.anext = 1'b1;
        wa       = found;
        wd.anext = {1'b0, slot};
      end
      S_A_SP3: begin
        if (sfba_pkg::live(fanext)) begin
          wm.aprev = 1'b1;
          wa       = fanext[sfba_pkg::SLOT_W-1:0];
          wd.aprev = {1'b0, slot};
        end
      end
      S_A_SP4: begin
        if (sfba_pkg::live(hd_old)) begin
          wm.bprev = 1'b1;
          wa       = hd_old[sfba_pkg::SLOT_W-1:0];
          wd.bprev = {1'b0, slot};
        end
      end
      S_A_SP5: begin
        wm.size = 1'b1;
        wa      = found;
        wd.size = n16;
      end
      S_UL1: begin
        if (sfba_pkg::live(un)) begin
          wm.bprev = 1'b1;
          wa       = un[sfba_pkg::SLOT_W-1:0];
          wd.bprev = up;
        end
      end
      S_UL2: begin
        if (sfba_pkg::live(up)) begin
          wm.bnext = 1'b1;
          wa       = up[sfba_pkg::SLOT_W-1:0];
          wd.bnext = un;
        end else begin
          hd_idx = sfba_pkg::bucket_of({1'b0, usz});
          hd_we  = 1'b1;
          hd_wd  = un;
        end
      end
      S_UL3: begin
        wm.bnext = 1'b1;
        wm.bprev = 1'b1;
        wm.busy  = 1'b1;
        wa       = ux;
        wd.bnext = sfba_pkg::NIL;
        wd.bprev = sfba_pkg::NIL;
        wd.busy  = 1'b1;
      end
      S_F_START: begin
        ra = hnd;
      end
      S_F_CHKH: begin
        ra = rdata.anext[sfba_pkg::SLOT_W-1:0];
      end
      S_F_MR1: begin
        wm.size  = 1'b1;
        wm.anext = 1'b1;
        wa       = hnd;
        wd.size  = tsz;
        wd.anext = tnext;
      end
      S_F_MR2: begin
        if (sfba_pkg::live(tnext)) begin
          wm.aprev = 1'b1;
          wa       = tnext[sfba_pkg::SLOT_W-1:0];
          wd.aprev = {1'b0, hnd};
        end
      end
      S_F_RDH2: begin
        ra = hnd;
      end
      S_F_LFT: begin
        ra = rdata.aprev[sfba_pkg::SLOT_W-1:0];
      end
      S_F_ML1: begin
        wm.size  = 1'b1;
        wm.anext = 1'b1;
        wa       = ux;
        wd.size  = tsz;
        wd.anext = tnext;
      end
      S_F_ML2: begin
        if (sfba_pkg::live(tnext)) begin
          wm.aprev = 1'b1;
          wa       = tnext[sfba_pkg::SLOT_W-1:0];
          wd.aprev = {1'b0, ux};
        end
      end
      S_F_LINK: begin
        hd_idx   = sfba_pkg::bucket_of({1'b0, tsz});
        wm.bnext = 1'b1;
        wm.bprev = 1'b1;
        wm.busy  = 1'b1;
        wa       = fh;
        wd.bnext = hd_rd;
        wd.bprev = sfba_pkg::NIL;
        wd.busy  = 1'b0;
        hd_we    = 1'b1;
        hd_wd    = {1'b0, fh};
      end
      S_F_LINK2: begin
        if (sfba_pkg::live(hd_old)) begin
          wm.bprev = 1'b1;
          wa       = hd_old[sfba_pkg::SLOT_W-1:0];
          wd.bprev = {1'b0, fh};
        end
      end
      default: begin
      end
    endcase
  end

  // Node memory with per-field write enables and a registered read.
  always_ff @(posedge clk) begin
    if (wm.size)  mem[wa].size  <= wd.size;
    if (wm.off)   mem[wa].off   <= wd.off;
    if (wm.pool)  mem[wa].pool  <= wd.pool;
    if (wm.busy)  mem[wa].busy  <= wd.busy;
    if (wm.anext) mem[wa].anext <= wd.anext;
    if (wm.aprev) mem[wa].aprev <= wd.aprev;
    if (wm.bnext) mem[wa].bnext <= wd.bnext;
    if (wm.bprev) mem[wa].bprev <= wd.bprev;
    rdata <= mem[ra];
  end

  // Sequencer, bucket heads, slot map and result registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      st    <= S_IDLE;
      done  <= 1'b0;
      pools <= '0;
      sfree <= '1;
      slack <= sfba_pkg::SIZE_W'(sfba_pkg::SLACK_RESET);
      for (int i = 0; i < sfba_pkg::BUCKETS; i++) begin
        vhead[i] <= sfba_pkg::NIL;
        ihead[i] <= sfba_pkg::NIL;
      end
    end else begin
      done <= 1'b0;
      if (cfg_we) slack <= cfg_wdata;

      if (hd_we) begin
        if (is_v) vhead[hd_idx] <= hd_wd;
        else      ihead[hd_idx] <= hd_wd;
      end

      case (st)
        S_IDLE: begin
          if (start) begin
            is_v    <= is_vertex;
            n       <= item_count;
            hnd     <= node_handle;
            st      <= req_type ? S_F_START : S_A_START;
          end
        end

        // Allocate: size check, then scan buckets upward.
        S_A_START: begin
          if (is_v ? (n > sfba_pkg::CNT_W'(sfba_pkg::VERTEX_POOL_ITEMS))
                   : (n > sfba_pkg::CNT_W'(sfba_pkg::INDEX_LIMIT))) begin
            done          <= 1'b1;
            status        <= sfba_pkg::STATUS_TOO_LARGE;
            region_handle <= '0;
            region_offset <= '0;
            region_pool   <= '0;
            region_size   <= '0;
            st            <= S_IDLE;
          end else begin
            e  <= sfba_pkg::bucket_of(n);
            st <= S_A_HEAD;
          end
        end
        S_A_HEAD: begin
          if (e >= sfba_pkg::BKT_W'(sfba_pkg::BUCKETS)) begin
            st <= S_A_NOFIT;
          end else begin
            cur   <= hd_rd;
            steps <= '0;
            st    <= S_A_WALK;
          end
        end
        S_A_WALK: begin
          if (!sfba_pkg::live(cur) ||
              steps == sfba_pkg::PTR_W'(sfba_pkg::NODE_SLOTS)) begin
            e  <= e + 1'b1;
            st <= S_A_HEAD;
          end else begin
            st <= S_A_CHK;
          end
        end
        S_A_CHK: begin
          if ({1'b0, rdata.size} > n) begin
            found  <= cur[sfba_pkg::SLOT_W-1:0];
            fsize  <= rdata.size;
            foff   <= rdata.off;
            fpool  <= rdata.pool;
            fanext <= rdata.anext;
            ux     <= cur[sfba_pkg::SLOT_W-1:0];
            un     <= rdata.bnext;
            up     <= rdata.bprev;
            usz    <= rdata.size;
            ret    <= S_A_SPCHK;
            st     <= S_UL1;
          end else begin
            cur   <= rdata.bnext;
            steps <= steps + 1'b1;
            st    <= S_A_WALK;
          end
        end

        // Nothing fits: open a fresh pool in a new slot.
        S_A_NOFIT: begin
          if (pools >= sfba_pkg::POOL_CNT_W'(sfba_pkg::MAX_POOLS)) begin
            done          <= 1'b1;
            status        <= sfba_pkg::STATUS_NO_POOL;
            region_handle <= '0;
            region_offset <= '0;
            region_pool   <= '0;
            region_size   <= '0;
            st            <= S_IDLE;
          end else begin
            sret <= S_A_POOL;
            st   <= S_SF_G;
          end
        end
        S_A_POOL: begin
          if (!slot_ok) begin
            done          <= 1'b1;
            status        <= sfba_pkg::STATUS_NO_SLOT;
            region_handle <= '0;
            region_offset <= '0;
            region_pool   <= '0;
            region_size   <= '0;
            st            <= S_IDLE;
          end else begin
            found  <= slot;
            fsize  <= pool_items;
            foff   <= '0;
            fpool  <= pools[sfba_pkg::POOL_W-1:0];
            fanext <= sfba_pkg::NIL;
            pools  <= pools + 1'b1;
            st     <= S_A_SPCHK;
          end
        end

        // Split when the block exceeds the request by more than the slack.
        S_A_SPCHK: begin
          if ({1'b0, fsize} > n + {1'b0, slack}) begin
            sret <= S_A_SP1;
            st   <= S_SF_G;
          end else begin
            st <= S_A_GRANT;
          end
        end
        S_A_SP1: begin
          hd_old <= hd_rd;
          st     <= slot_ok ? S_A_SP2 : S_A_GRANT;
        end
        S_A_SP2: st <= S_A_SP3;
        S_A_SP3: st <= S_A_SP4;
        S_A_SP4: st <= S_A_SP5;
        S_A_SP5: begin
          fsize <= n16;
          st    <= S_A_GRANT;
        end
        S_A_GRANT: begin
          done          <= 1'b1;
          status        <= sfba_pkg::STATUS_OK;
          region_handle <= found;
          region_offset <= foff;
          region_pool   <= fpool;
          region_size   <= fsize;
          st            <= S_IDLE;
        end

        // Bucket unlink of node ux, shared by allocate and free.
        S_UL1: st <= S_UL2;
        S_UL2: st <= S_UL3;
        S_UL3: st <= ret;

        // Lowest free slot search, in two steps.
        S_SF_G: begin
          if (|grp_any) begin
            grp <= grp_pick;
            st  <= S_SF_B;
          end else begin
            slot_ok <= 1'b0;
            st      <= sret;
          end
        end
        S_SF_B: begin
          slot                       <= {grp, pos_pick};
          slot_ok                    <= 1'b1;
          sfree[{grp, pos_pick}]     <= 1'b0;
          st                         <= sret;
        end

        // Free: check the handle, then merge with the right neighbour.
        S_F_START: begin
          if (sfree[hnd]) begin
            done          <= 1'b1;
            status        <= sfba_pkg::STATUS_OK;
            region_handle <= '0;
            region_offset <= '0;
            region_pool   <= '0;
            region_size   <= '0;
            st            <= S_IDLE;
          end else begin
            st <= S_F_CHKH;
          end
        end
        S_F_CHKH: begin
          if (!rdata.busy) begin
            done          <= 1'b1;
            status        <= sfba_pkg::STATUS_OK;
            region_handle <= '0;
            region_offset <= '0;
            region_pool   <= '0;
            region_size   <= '0;
            st            <= S_IDLE;
          end else begin
            tsz <= rdata.size;
            if (sfba_pkg::live(rdata.anext) &&
                !sfree[rdata.anext[sfba_pkg::SLOT_W-1:0]]) begin
              ux <= rdata.anext[sfba_pkg::SLOT_W-1:0];
              st <= S_F_CHKR;
            end else begin
              st <= S_F_RDH2;
            end
          end
        end
        S_F_CHKR: begin
          if (!rdata.busy) begin
            un    <= rdata.bnext;
            up    <= rdata.bprev;
            usz   <= rdata.size;
            tsz   <= tsz + rdata.size;
            tnext <= rdata.anext;
            ret   <= S_F_MR1;
            st    <= S_UL1;
          end else begin
            st <= S_F_RDH2;
          end
        end
        S_F_MR1: st <= S_F_MR2;
        S_F_MR2: begin
          sfree[ux] <= 1'b1;
          st        <= S_F_RDH2;
        end

        // Merge with the left neighbour from a fresh read of the node.
        S_F_RDH2: st <= S_F_LFT;
        S_F_LFT: begin
          tsz   <= rdata.size;
          tnext <= rdata.anext;
          if (sfba_pkg::live(rdata.aprev) &&
              !sfree[rdata.aprev[sfba_pkg::SLOT_W-1:0]]) begin
            ux <= rdata.aprev[sfba_pkg::SLOT_W-1:0];
            st <= S_F_CHKL;
          end else begin
            fh <= hnd;
            st <= S_F_LINK;
          end
        end
        S_F_CHKL: begin
          if (!rdata.busy) begin
            un  <= rdata.bnext;
            up  <= rdata.bprev;
            usz <= rdata.size;
            tsz <= rdata.size + tsz;
            ret <= S_F_ML1;
            st  <= S_UL1;
          end else begin
            fh <= hnd;
            st <= S_F_LINK;
          end
        end
        S_F_ML1: st <= S_F_ML2;
        S_F_ML2: begin
          sfree[hnd] <= 1'b1;
          fh         <= ux;
          st         <= S_F_LINK;
        end

        // Return the merged block to the head of its bucket.
        S_F_LINK: begin
          hd_old <= hd_rd;
          st     <= S_F_LINK2;
        end
        S_F_LINK2: begin
          done          <= 1'b1;
          status        <= sfba_pkg::STATUS_OK;
          region_handle <= '0;
          region_offset <= '0;
          region_pool   <= '0;
          region_size   <= '0;
          st            <= S_IDLE;
        end

        default: st <= S_IDLE;
      endcase
    end
  end

  // Checks on sequencing and results.
  `SFBA_ASSERT_SAME(a_done_idle, done, !busy, "result shown while still busy")
  `SFBA_ASSERT_NEXT(a_start_busy, start && !busy, busy, "accepted command did not start")
  `SFBA_ASSERT_SAME(a_err_zero, done && (status != sfba_pkg::STATUS_OK), (region_size == '0) && (region_handle == '0), "error result carries a region")
  `SFBA_ASSERT_NEVER(a_pool_cnt, pools > sfba_pkg::POOL_CNT_W'(sfba_pkg::MAX_POOLS), "pool counter overran")

endmodule

// ===== dv/segregated_fit_buffer_allocator_test.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Segregated fit buffer allocator testbench
// Drives allocate and free commands into both allocators, with idle gaps and
// several split_slack settings. A scoreboard keeps its own model of the slot
// table, bucket lists and pools, and checks every result field by field.
// ----------------------------------------------------------------------------
module segregated_fit_buffer_allocator_test;

  localparam int CYCLE_LIMIT = 40000000;
  localparam int NULL_SLOT   = sfba_pkg::NODE_SLOTS;

  typedef struct {
    sfba_pkg::status_t st;
    logic [7:0]  handle;
    logic [15:0] offset;
    logic [3:0]  pool;
    logic [15:0] size;
  } region_grant_t;

  typedef struct {
    logic [7:0] handle;
    bit         vert;
  } held_region_t;

  // Allocator model and queue of outstanding grants.
  class alloc_scoreboard;
    int          slack;
    logic [15:0] bsize[sfba_pkg::NODE_SLOTS];
    logic [15:0] boff[sfba_pkg::NODE_SLOTS];
    int          bpool[sfba_pkg::NODE_SLOTS];
    bit          bbusy[sfba_pkg::NODE_SLOTS];
    int          anext[sfba_pkg::NODE_SLOTS];
    int          aprev[sfba_pkg::NODE_SLOTS];
    int          bnext[sfba_pkg::NODE_SLOTS];
    int          bprev[sfba_pkg::NODE_SLOTS];
    bit          slot_free[sfba_pkg::NODE_SLOTS];
    int          head[2][sfba_pkg::BUCKETS];
    int          pools;
    region_grant_t pending[$];
    held_region_t  held[$];
    int errors;
    int n_alloc, n_free, n_ok, n_large, n_nopool, n_noslot;

    function new();
      slack = sfba_pkg::SLACK_RESET;
      pools = 0;
      for (int i = 0; i < sfba_pkg::NODE_SLOTS; i++) begin
        slot_free[i] = 1;
        bbusy[i] = 0;
      end
      foreach (head[k, e]) head[k][e] = NULL_SLOT;
    endfunction

    function int bucket_for(int count);
      int lg;
      int v;
      lg = 0;
      if (count > 1) begin
        v = count - 1;
        while (v != 0) begin
          lg++;
          v = v >> 1;
        end
      end
      if (lg < sfba_pkg::FIRST_BUCKET) return 0;
      lg -= sfba_pkg::FIRST_BUCKET;
      return (lg > sfba_pkg::BUCKETS - 1) ? sfba_pkg::BUCKETS - 1 : lg;
    endfunction

    function bit ok_ptr(int p);
      return p >= 0 && p < sfba_pkg::NODE_SLOTS;
    endfunction

    function void unlink(int h, bit v);
      int n;
      int p;
      n = bnext[h];
      p = bprev[h];
      if (ok_ptr(n)) bprev[n] = p;
      if (ok_ptr(p)) bnext[p] = n;
      else head[v][bucket_for(bsize[h])] = n;
      bnext[h] = NULL_SLOT;
      bprev[h] = NULL_SLOT;
      bbusy[h] = 1;
    endfunction

    function void link(int h, bit v);
      int e;
      e = bucket_for(bsize[h]);
      bprev[h] = NULL_SLOT;
      bbusy[h] = 0;
      bnext[h] = head[v][e];
      head[v][e] = h;
      if (ok_ptr(bnext[h])) bprev[bnext[h]] = h;
    endfunction

    function int grab_slot();
      for (int i = 0; i < sfba_pkg::NODE_SLOTS; i++) begin
        if (slot_free[i]) begin
          slot_free[i] = 0;
          return i;
        end
      end
      return NULL_SLOT;
    endfunction

    function region_grant_t allocate(int n, bit v);
      region_grant_t r;
      int lim;
      int found;
      int h;
      int steps;
      int s;
      r = '{sfba_pkg::STATUS_OK, 8'd0, 16'd0, 4'd0, 16'd0};
      lim = v ? sfba_pkg::VERTEX_POOL_ITEMS : sfba_pkg::INDEX_LIMIT;
      found = NULL_SLOT;
      if (n > lim) begin
        r.st = sfba_pkg::STATUS_TOO_LARGE;
        return r;
      end
      for (int e = bucket_for(n); e < sfba_pkg::BUCKETS && !ok_ptr(found); e++) begin
        h = head[v][e];
        steps = 0;
        while (ok_ptr(h) && steps < sfba_pkg::NODE_SLOTS) begin
          if (bsize[h] > n) begin
            found = h;
            break;
          end
          h = bnext[h];
          steps++;
        end
      end
      if (!ok_ptr(found)) begin
        if (pools >= sfba_pkg::MAX_POOLS) begin
          r.st = sfba_pkg::STATUS_NO_POOL;
          return r;
        end
        found = grab_slot();
        if (!ok_ptr(found)) begin
          r.st = sfba_pkg::STATUS_NO_SLOT;
          return r;
        end
        bsize[found] = 16'(v ? sfba_pkg::VERTEX_POOL_ITEMS : sfba_pkg::INDEX_POOL_ITEMS);
        boff[found]  = 0;
        bpool[found] = pools;
        anext[found] = NULL_SLOT;
        aprev[found] = NULL_SLOT;
        bnext[found] = NULL_SLOT;
        bprev[found] = NULL_SLOT;
        bbusy[found] = 1;
        pools++;
      end else begin
        unlink(found, v);
      end
      // Split off the remainder when it exceeds the slack.
      if (int'(bsize[found]) > n + slack) begin
        s = grab_slot();
        if (ok_ptr(s)) begin
          bsize[s] = bsize[found] - 16'(n);
          boff[s]  = boff[found] + 16'(n);
          bpool[s] = bpool[found];
          anext[s] = anext[found];
          aprev[s] = found;
          anext[found] = s;
          if (ok_ptr(anext[s])) aprev[anext[s]] = s;
          link(s, v);
          bsize[found] = 16'(n);
        end
      end
      r.handle = 8'(found);
      r.offset = boff[found];
      r.pool   = 4'(bpool[found]);
      r.size   = bsize[found];
      return r;
    endfunction

    function void release_region(int h, bit v);
      int rn;
      int ln;
      if (!ok_ptr(h) || slot_free[h] || !bbusy[h]) return;
      // Merge with the right neighbour first, then the left one.
      rn = anext[h];
      if (ok_ptr(rn) && !slot_free[rn] && !bbusy[rn]) begin
        unlink(rn, v);
        bsize[h] = bsize[h] + bsize[rn];
        anext[h] = anext[rn];
        if (ok_ptr(anext[h])) aprev[anext[h]] = h;
        slot_free[rn] = 1;
      end
      ln = aprev[h];
      if (ok_ptr(ln) && !slot_free[ln] && !bbusy[ln]) begin
        unlink(ln, v);
        bsize[ln] = bsize[ln] + bsize[h];
        anext[ln] = anext[h];
        if (ok_ptr(anext[ln])) aprev[anext[ln]] = ln;
        slot_free[h] = 1;
        h = ln;
      end
      link(h, v);
    endfunction

    // Called for every accepted command transfer.
    function void note_request(bit is_free, bit v, int cnt, int hnd);
      region_grant_t r;
      r = '{sfba_pkg::STATUS_OK, 8'd0, 16'd0, 4'd0, 16'd0};
      if (is_free) begin
        n_free++;
        release_region(hnd, v);
      end else begin
        n_alloc++;
        r = allocate(cnt, v);
        case (r.st)
          sfba_pkg::STATUS_OK:        begin n_ok++; held.push_back('{r.handle, v}); end
          sfba_pkg::STATUS_TOO_LARGE: n_large++;
          sfba_pkg::STATUS_NO_POOL:   n_nopool++;
          default:                    n_noslot++;
        endcase
      end
      pending.push_back(r);
    endfunction

    // Called for every result transfer.
    function void check_result(logic [1:0] st, logic [7:0] h, logic [15:0] off,
                               logic [3:0] pl, logic [15:0] sz);
      region_grant_t x;
      if (pending.size() == 0) begin
        errors++;
        if (errors <= 10) $display("ERROR: result with nothing outstanding, status %0d", st);
        return;
      end
      x = pending.pop_front();
      if (st !== x.st || h !== x.handle || off !== x.offset || pl !== x.pool ||
          sz !== x.size) begin
        errors++;
        if (errors <= 10)
          $display("ERROR: expected st %0d h %0d off %0d pool %0d size %0d, got %0d %0d %0d %0d %0d",
                   x.st, x.handle, x.offset, x.pool, x.size, st, h, off, pl, sz);
      end
    endfunction
  endclass

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        start = 1'b0;
  logic        busy;
  logic        req_type = 1'b0;
  logic        is_vertex = 1'b0;
  logic [16:0] item_count = '0;
  logic [7:0]  node_handle = '0;
  logic        cfg_we = 1'b0;
  logic [15:0] cfg_wdata = '0;
  logic        done;
  logic [1:0]  status;
  logic [7:0]  region_handle;
  logic [15:0] region_offset;
  logic [3:0]  region_pool;
  logic [15:0] region_size;

  alloc_scoreboard sb = new();
  int  cycles = 0;
  bit  quiet_stretch = 0;

  segregated_fit_buffer_allocator uut (
    .clk(clk), .rst(rst), .start(start), .busy(busy),
    .req_type(req_type), .is_vertex(is_vertex), .item_count(item_count),
    .node_handle(node_handle), .cfg_we(cfg_we), .cfg_wdata(cfg_wdata),
    .done(done), .status(status), .region_handle(region_handle),
    .region_offset(region_offset), .region_pool(region_pool),
    .region_size(region_size)
  );

  initial begin
    forever #1 clk = ~clk;
  end

  // Result monitor and run limit.
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (!rst && done) sb.check_result(status, region_handle, region_offset, region_pool,
                                      region_size);
    if (cycles >= CYCLE_LIMIT) begin
      $display("Timed out with %0d results outstanding", sb.pending.size());
      $display("segregated_fit_buffer_allocator_test: FAIL");
      $finish;
    end
  end

  // Present one command and hold it until the transfer; start stays high.
  // The model sees only the bits that reach the ports.
  task automatic send_command(bit is_free, bit v, int cnt, int hnd);
    start       <= 1'b1;
    req_type    <= is_free;
    is_vertex   <= v;
    item_count  <= 17'(cnt);
    node_handle <= 8'(hnd);
    @(posedge clk);
    while (busy) @(posedge clk);
    sb.note_request(is_free, v, cnt & 'h1ffff, hnd & 'hff);
    if (!quiet_stretch && $urandom_range(99) < 9) begin
      start <= 1'b0;
      repeat ($urandom_range(1, 6)) @(posedge clk);
    end
  endtask

  task automatic drain_and_configure(int value);
    start <= 1'b0;
    @(posedge clk);
    while (sb.pending.size() != 0) @(posedge clk);
    repeat (40) @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_wdata <= 16'(value);
    @(posedge clk);
    cfg_we <= 1'b0;
    sb.slack = value;
  endtask

  task automatic free_held(bit mislabel);
    int k;
    held_region_t hr;
    k  = $urandom_range(sb.held.size() - 1);
    hr = sb.held[k];
    sb.held.delete(k);
    send_command(1'b1, mislabel ? !hr.vert : hr.vert, $urandom, hr.handle);
  endtask

  // Random mix: alloc_pct of allocations, the rest mostly frees of held regions.
  task automatic random_phase(int items, int alloc_pct, int small_max);
    int  p;
    bit  v;
    int  cnt;
    for (int i = 0; i < items; i++) begin
      quiet_stretch = (i >= items / 3 && i < items / 2);
      p = $urandom_range(99);
      v = $urandom_range(1);
      if (p < alloc_pct) begin
        case ($urandom_range(9))
          0:       cnt = v ? $urandom_range(65535) : $urandom_range(sfba_pkg::INDEX_LIMIT);
          1:       cnt = $urandom_range(131071);
          default: cnt = $urandom_range(small_max);
        endcase
        send_command(1'b0, v, cnt, $urandom);
      end else if (p < 96 && sb.held.size() != 0) begin
        free_held($urandom_range(19) == 0);
      end else begin
        send_command(1'b1, v, $urandom, $urandom);
      end
    end
    quiet_stretch = 0;
  endtask

  initial begin
    repeat (4) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed: size extremes, limits, splits and coalescing, bad frees.
    send_command(1'b1, 1'b1, 0, 255);
    send_command(1'b0, 1'b1, 0, 0);
    send_command(1'b0, 1'b1, 1, 255);
    send_command(1'b0, 1'b1, 200, 0);
    send_command(1'b0, 1'b1, 65535, 0);
    send_command(1'b0, 1'b1, 65536, 0);
    send_command(1'b0, 1'b1, 131071, 0);
    send_command(1'b0, 1'b0, sfba_pkg::INDEX_LIMIT, 0);
    send_command(1'b0, 1'b0, sfba_pkg::INDEX_LIMIT + 1, 0);
    send_command(1'b0, 1'b0, 17, 0);
    send_command(1'b1, 1'b1, 0, 2);
    send_command(1'b1, 1'b1, 0, 1);
    send_command(1'b1, 1'b1, 0, 1);
    send_command(1'b1, 1'b1, 0, 0);
    send_command(1'b1, 1'b0, 0, 200);
    send_command(1'b0, 1'b0, 65000, 0);
    sb.held.delete();

    // Zero slack splits everything and soon runs out of slots.
    drain_and_configure(0);
    random_phase(450, 85, 40);
    drain_and_configure(65535);
    random_phase(350, 50, 3000);
    drain_and_configure(sfba_pkg::SLACK_RESET);
    random_phase(400, 55, 600);
    drain_and_configure($urandom_range(1, 65534));
    random_phase(400, 55, 20000);

    start <= 1'b0;
    @(posedge clk);
    while (sb.pending.size() != 0) @(posedge clk);
    repeat (50) @(posedge clk);
    $display("Covered %0d allocations (%0d granted, %0d too large, %0d no pool, %0d no slot)",
             sb.n_alloc, sb.n_ok, sb.n_large, sb.n_nopool, sb.n_noslot);
    $display("and %0d frees over four split_slack settings; %0d mismatches",
             sb.n_free, sb.errors);
    if (sb.errors == 0) begin
      $display("segregated_fit_buffer_allocator_test: PASS");
    end else begin
      $display("segregated_fit_buffer_allocator_test: FAIL");
    end
    $finish;
  end

endmodule
